[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out with NO_ASSERTIONS
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/bdg_pkg.sv]
// ----------------------------------------------------------------------------
// bdg_pkg
// shared types, constants and the 3x8 font rom of the glyph scaler
// ----------------------------------------------------------------------------
package bdg_pkg;

   localparam int CODE_W      = 5;
   localparam int BYTE_W      = 8;
   localparam int TOTAL_BYTES = 64;
   localparam int IDX_W       = $clog2(TOTAL_BYTES);
   localparam int GAP_BYTES   = 8;
   localparam int COL1_START  = 24;
   localparam int COL2_START  = 48;

   typedef struct packed {
      logic              active;
      logic [CODE_W-1:0] code;
      logic [IDX_W-1:0]  idx;
   } bdg_slot_type;

   // three font columns packed as {col0, col1, col2}; codes without a glyph are blank
   function automatic logic [3*BYTE_W-1:0] glyph_columns(input logic [CODE_W-1:0] code);
      logic [3*BYTE_W-1:0] cols;
      case (code)
         5'd0:    cols = 24'h7F417F;
         5'd1:    cols = 24'h00007F;
         5'd2:    cols = 24'h79494F;
         5'd3:    cols = 24'h41497F;
         5'd4:    cols = 24'h0F087E;
         5'd5:    cols = 24'h4F4979;
         5'd6:    cols = 24'h7F4979;
         5'd7:    cols = 24'h03017F;
         5'd8:    cols = 24'h7F497F;
         5'd9:    cols = 24'h4F497F;
         5'd10:   cols = 24'h7F097F;
         5'd11:   cols = 24'h7F4878;
         5'd12:   cols = 24'h7F4163;
         5'd13:   cols = 24'h78487F;
         5'd14:   cols = 24'h7F4941;
         5'd15:   cols = 24'h7F0901;
         5'd16:   cols = 24'h006000;
         5'd17:   cols = 24'h003600;
         5'd18:   cols = 24'h080808;
         default: cols = 24'h000000;
      endcase
      return cols;
   endfunction

   // low font bit fills the low nibble, high font bit the high nibble
   function automatic logic [BYTE_W-1:0] stretch_pair(input logic [1:0] two_bits);
      return {{4{two_bits[1]}}, {4{two_bits[0]}}};
   endfunction

endpackage

[rtl/bdg_seq.sv]
// ----------------------------------------------------------------------------
// bdg_seq
// input register and byte index counter for the glyph in progress
// ----------------------------------------------------------------------------
module bdg_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [bdg_pkg::CODE_W-1:0]       req_char_code,
   output logic                             busy,
   output bdg_pkg::bdg_slot_type            slot
);

   localparam logic [bdg_pkg::IDX_W-1:0] LAST_IDX =
      bdg_pkg::IDX_W'(bdg_pkg::TOTAL_BYTES - 1);

   logic                         active_ff, active_in;
   logic [bdg_pkg::CODE_W-1:0]   code_ff, code_in;
   logic [bdg_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                         accept;

   assign busy   = active_ff && (idx_ff != LAST_IDX);
   assign accept = start && !busy;

   always_comb begin
      active_in = active_ff;
      code_in   = code_ff;
      idx_in    = idx_ff;
      if (accept) begin
         active_in = 1'b1;
         code_in   = req_char_code;
         idx_in    = '0;
      end else if (active_ff) begin
         idx_in = idx_ff + bdg_pkg::IDX_W'(1);
         if (idx_ff == LAST_IDX) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff    <= '0;
      end else begin
         active_ff <= active_in;
         idx_ff    <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
   end

   assign slot.active = active_ff;
   assign slot.code   = code_ff;
   assign slot.idx    = idx_ff;

endmodule

[rtl/bdg_render.sv]
// ----------------------------------------------------------------------------
// bdg_render
// font lookup, vertical stretch and result register
// ----------------------------------------------------------------------------
module bdg_render (
   input  logic                             clock,
   input  logic                             reset,
   input  bdg_pkg::bdg_slot_type            slot,
   output logic                             rsp_strobe,
   output logic [bdg_pkg::BYTE_W-1:0]       rsp_pixel_byte,
   output logic                             rsp_last_byte
);

   localparam logic [bdg_pkg::IDX_W-1:0] GAP_END =
      bdg_pkg::IDX_W'(bdg_pkg::GAP_BYTES);
   localparam logic [bdg_pkg::IDX_W-1:0] COL1_IDX =
      bdg_pkg::IDX_W'(bdg_pkg::COL1_START);
   localparam logic [bdg_pkg::IDX_W-1:0] COL2_IDX =
      bdg_pkg::IDX_W'(bdg_pkg::COL2_START);
   localparam logic [bdg_pkg::IDX_W-1:0] LAST_IDX =
      bdg_pkg::IDX_W'(bdg_pkg::TOTAL_BYTES - 1);

   logic                           strobe_ff, strobe_in;
   logic [bdg_pkg::BYTE_W-1:0]     pixel_ff, pixel_in;
   logic                           last_ff, last_in;
   logic [3*bdg_pkg::BYTE_W-1:0]   cols;
   logic [bdg_pkg::BYTE_W-1:0]     font_byte;
   logic [1:0]                     pair;

   always_comb begin
      cols = bdg_pkg::glyph_columns(slot.code);
      if (slot.idx < COL1_IDX) begin
         font_byte = cols[3*bdg_pkg::BYTE_W-1 -: bdg_pkg::BYTE_W];
      end else if (slot.idx < COL2_IDX) begin
         font_byte = cols[2*bdg_pkg::BYTE_W-1 -: bdg_pkg::BYTE_W];
      end else begin
         font_byte = cols[bdg_pkg::BYTE_W-1:0];
      end
      // row within the four-byte group
      case (slot.idx[1:0])
         2'd0:    pair = font_byte[1:0];
         2'd1:    pair = font_byte[3:2];
         2'd2:    pair = font_byte[5:4];
         2'd3:    pair = font_byte[7:6];
         default: pair = 2'b00;
      endcase
      strobe_in = slot.active;
      last_in   = slot.idx == LAST_IDX;
      pixel_in  = (slot.idx < GAP_END) ? '0 : bdg_pkg::stretch_pair(pair);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      last_ff  <= last_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_pixel_byte = pixel_ff;
   assign rsp_last_byte  = strobe_ff && last_ff;

endmodule

[rtl/big_digit_glyph_scaler_unit.sv]
// ----------------------------------------------------------------------------
// big_digit_glyph_scaler_unit
// large glyph generator for a vertically addressed page display
// ----------------------------------------------------------------------------
// usage:
//   a character code is taken on req_char_code at a clock edge where start
//   is high and busy is low. codes 0-15 are hex digits, 16 dot, 17 colon,
//   18 dash, 19 space, the rest draw blank.
//   each code gives 64 display bytes on rsp_pixel_byte, one per cycle, each
//   marked by rsp_strobe for one cycle; rsp_last_byte flags the 64th.
//   order: 8 zero gap bytes, then the first font column (4 x 4 bytes), the
//   middle column (6 x 4 bytes) and the third column (4 x 4 bytes).
//   the code and byte index are captured in the slot registers at the
//   transfer edge, and each byte then passes through the result register.
//   the byte counter, which drives the single result register, takes a new
//   code only when it is through with the last; busy drops while byte 63 is
//   being formed, so the next code follows with no gap in the byte stream.
//   reset clears the counter and the strobe; no code is in progress after.
//   the receiver cannot stall: every strobed byte must be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module big_digit_glyph_scaler_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [bdg_pkg::CODE_W-1:0]       req_char_code,
   output logic                             rsp_strobe,
   output logic [bdg_pkg::BYTE_W-1:0]       rsp_pixel_byte,
   output logic                             rsp_last_byte
);

   bdg_pkg::bdg_slot_type slot;
   logic                  gap_out;

   bdg_seq u_seq (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_char_code (req_char_code),
      .busy          (busy),
      .slot          (slot)
   );

   bdg_render u_render (
      .clock          (clock),
      .reset          (reset),
      .slot           (slot),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   assign gap_out = rsp_strobe && (rsp_pixel_byte == '0) && !rsp_last_byte;

   // a busy cycle always produces a byte in the next cycle
   `ASSERT_NEXT(a_busy_emits, clock, reset, busy, rsp_strobe)
   // the first byte after a transfer is a gap byte
   `ASSERT_IMPLIES(a_gap_first, clock, reset, start && !busy, ##2 gap_out)
   // end markers never come back to back
   `ASSERT_NEXT(a_last_spaced, clock, reset, rsp_last_byte, !rsp_last_byte)
   // counter in progress while a byte other than the last one leaves
   `ASSERT_IMPLIES(a_stream_busy, clock, reset, rsp_strobe && !rsp_last_byte, slot.active)

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench for big_digit_glyph_scaler_unit
// sends character codes and checks every display byte against a predicted
// 64-byte glyph: the zero gap, then the three font columns with each font
// bit stretched to four pixels, the outer columns four times and the middle
// column six times; codes without a glyph must come out blank
// ----------------------------------------------------------------------------
module testbench;

   localparam int NUM_GLYPHS = 20;

   localparam logic [23:0] GLYPH_FONT [NUM_GLYPHS] = '{
      24'h7F417F, 24'h00007F, 24'h79494F, 24'h41497F, 24'h0F087E,
      24'h4F4979, 24'h7F4979, 24'h03017F, 24'h7F497F, 24'h4F497F,
      24'h7F097F, 24'h7F4878, 24'h7F4163, 24'h78487F, 24'h7F4941,
      24'h7F0901, 24'h006000, 24'h003600, 24'h080808, 24'h000000
   };

   typedef struct packed {
      logic [bdg_pkg::BYTE_W-1:0] pixel;
      logic                       last;
   } glyph_byte_type;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [bdg_pkg::CODE_W-1:0]   req_char_code;
   logic                         rsp_strobe;
   logic [bdg_pkg::BYTE_W-1:0]   rsp_pixel_byte;
   logic                         rsp_last_byte;

   glyph_byte_type      glyph_bytes_q[$];
   glyph_byte_type      expected_byte;
   int                  error_count = 0;

   big_digit_glyph_scaler_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_char_code  (req_char_code),
      .rsp_strobe     (rsp_strobe),
      .rsp_pixel_byte (rsp_pixel_byte),
      .rsp_last_byte  (rsp_last_byte)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // expected display bytes of one character
   function automatic void predict_glyph(input logic [bdg_pkg::CODE_W-1:0] code);
      logic [23:0]                cols;
      logic [bdg_pkg::BYTE_W-1:0] font_col;
      logic [bdg_pkg::BYTE_W-1:0] rows [4];
      glyph_byte_type             b;
      int                         n;
      int                         reps;
      cols = (code < NUM_GLYPHS) ? GLYPH_FONT[code] : 24'h000000;
      n = 0;
      for (int g = 0; g < bdg_pkg::GAP_BYTES; g++) begin
         b.pixel = '0;
         b.last  = 1'b0;
         glyph_bytes_q.push_back(b);
         n++;
      end
      for (int col = 0; col < 3; col++) begin
         font_col = cols[8*(2-col) +: 8];
         for (int row = 0; row < 4; row++)
            rows[row] = (font_col[2*row] ? 8'h0F : 8'h00) |
                        (font_col[2*row+1] ? 8'hF0 : 8'h00);
         reps = (col == 1) ? 6 : 4;
         for (int r = 0; r < reps; r++) begin
            for (int row = 0; row < 4; row++) begin
               b.pixel = rows[row];
               b.last  = (n == bdg_pkg::TOTAL_BYTES - 1);
               glyph_bytes_q.push_back(b);
               n++;
            end
         end
      end
   endfunction

   // one code transfer; start stays high until idle_sender drives it low
   task automatic send_code(input logic [bdg_pkg::CODE_W-1:0] code);
      @(negedge clock);
      start         <= 1'b1;
      req_char_code <= code;
      do
         @(posedge clock);
      while (busy);
      predict_glyph(code);
   endtask

   task automatic idle_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         start         <= 1'b0;
         req_char_code <= bdg_pkg::CODE_W'($urandom);
      end
   endtask

   function automatic logic [bdg_pkg::CODE_W-1:0] random_code();
      if ($urandom_range(0, 3) == 0)
         return bdg_pkg::CODE_W'($urandom_range(NUM_GLYPHS, 31));
      return bdg_pkg::CODE_W'($urandom_range(0, NUM_GLYPHS - 1));
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (glyph_bytes_q.size() == 0) begin
            $display("%0t: unexpected byte %02h last %0b", $time, rsp_pixel_byte,
                     rsp_last_byte);
            error_count++;
         end else begin
            expected_byte = glyph_bytes_q.pop_front();
            if (rsp_pixel_byte !== expected_byte.pixel) begin
               $display("%0t: pixel_byte expected %02h actual %02h", $time,
                        expected_byte.pixel, rsp_pixel_byte);
               error_count++;
            end
            if (rsp_last_byte !== expected_byte.last) begin
               $display("%0t: last_byte expected %0b actual %0b", $time,
                        expected_byte.last, rsp_last_byte);
               error_count++;
            end
         end
      end
   end

   task automatic test_every_glyph();
      for (int c = 0; c < NUM_GLYPHS; c++)
         send_code(bdg_pkg::CODE_W'(c));
   endtask

   task automatic test_blank_codes();
      send_code(bdg_pkg::CODE_W'(NUM_GLYPHS));
      idle_sender(3);
      send_code(bdg_pkg::CODE_W'(27));
      send_code(bdg_pkg::CODE_W'(31));
      idle_sender(70);
   endtask

   task automatic test_random_bursts(input int num_items);
      int sent;
      int burst;
      sent = 0;
      while (sent < num_items) begin
         burst = $urandom_range(1, 6);
         for (int i = 0; i < burst && sent < num_items; i++) begin
            send_code(random_code());
            sent++;
         end
         if ($urandom_range(0, 3) != 0)
            idle_sender($urandom_range(1, 80));
      end
      idle_sender(1);
   endtask

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_char_code = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idle_sender(4);

      test_every_glyph();
      test_blank_codes();
      test_random_bursts(260);

      while (glyph_bytes_q.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      if (error_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
